// ----- design/tocs_pkg.sv -----
`timescale 1ns / 1ps
package tocs_pkg;
    localparam int SORTED_DEPTH   = 16;
    localparam int INCOMING_DEPTH = 8;
    localparam int LIST_IDX_W     = $clog2(SORTED_DEPTH);
    localparam int LIST_CNT_W     = $clog2(SORTED_DEPTH + 1);
    localparam int RING_IDX_W     = $clog2(INCOMING_DEPTH);
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_IDX_W    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [0:0] REG_IS_DIGITAL    = 1'b0;
    localparam logic [0:0] REG_MERGE_OVERLAP = 1'b1;

    typedef struct packed {
        logic               mode;
        logic        [31:0] cmd_time;
        logic signed [15:0] cmd_value;
        logic        [31:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic        [31:0] due_time;
        logic signed [15:0] due_value;
        logic               last;
    } out_item_t;

    // work handed from the front part to the back part
    typedef struct packed {
        logic               is_tick;
        logic        [31:0] t;
        logic signed [15:0] v;
    } job_t;

    typedef struct packed {
        logic is_digital;
        logic merge_overlap;
    } cfg_t;

    function automatic logic time_before(input logic [31:0] t, input logic [31:0] now);
        logic [31:0] d;
        d = t - now;
        return d[31];
    endfunction
endpackage

// ----- design/tocs_front.sv -----
`timescale 1ns / 1ps
module tocs_front
    import tocs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     q_valid,
    input  logic     q_ready,
    output job_t     q_job
);
    job_t                   buf_reg [QUEUE_DEPTH];
    logic [QUEUE_IDX_W-1:0] rd_reg, rd_next, wr_reg, wr_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                   push, pop;

    assign s_ready = (cnt_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_job   = buf_reg[rd_reg];

    always_comb begin
        rd_next  = rd_reg;
        wr_next  = wr_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    // classify the request: tick carries now, add carries the command
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_reg].is_tick <= (s_data.mode == MODE_TICK);
            buf_reg[wr_reg].t       <= (s_data.mode == MODE_TICK) ? s_data.now_time
                                                                  : s_data.cmd_time;
            buf_reg[wr_reg].v       <= s_data.cmd_value;
        end
    end
endmodule

// ----- design/tocs_back.sv -----
`timescale 1ns / 1ps
module tocs_back
    import tocs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      q_valid,
    output logic      q_ready,
    input  job_t      q_job,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOVE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_MERGE = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]             st_reg;
    logic [31:0]            rt_reg [INCOMING_DEPTH];
    logic [15:0]            rv_reg [INCOMING_DEPTH];
    logic [RING_IDX_W-1:0]  head_reg, tail_reg;
    logic [31:0]            lt_reg [SORTED_DEPTH];
    logic [15:0]            lv_reg [SORTED_DEPTH];
    logic [LIST_CNT_W-1:0]  cnt_reg;
    logic [31:0]            now_reg;
    logic                   moved_reg;
    logic [LIST_CNT_W-1:0]  pos_reg;
    logic [LIST_CNT_W-1:0]  mi_reg;
    logic [LIST_CNT_W-1:0]  open_reg;
    logic                   ov_reg;
    out_item_t              out_reg;

    logic [RING_IDX_W-1:0]  tail_inc, head_inc;
    logic [31:0]            ins_t;
    logic [15:0]            ins_v;
    logic [LIST_IDX_W-1:0]  pos_idx, pm1_idx, mi_idx;
    logic                   scan_stop, head_due, mdrop;
    logic [LIST_CNT_W-1:0]  open_upd;

    assign tail_inc = (tail_reg == RING_IDX_W'(INCOMING_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign head_inc = (head_reg == RING_IDX_W'(INCOMING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign ins_t    = rt_reg[head_reg];
    assign ins_v    = rv_reg[head_reg];
    assign pos_idx  = pos_reg[LIST_IDX_W-1:0];
    assign pm1_idx  = LIST_IDX_W'(pos_reg - 1'b1);
    assign mi_idx   = mi_reg[LIST_IDX_W-1:0];
    assign scan_stop = (pos_reg == '0) ||
                       !((lt_reg[pm1_idx] - now_reg) > (ins_t - now_reg));
    assign head_due = (cnt_reg != '0) && time_before(lt_reg[0], now_reg);
    assign q_ready  = (st_reg == ST_IDLE);
    assign m_valid  = ov_reg;
    assign m_data   = out_reg;

    // open-on counter of the overlap merge, saturating at zero
    always_comb begin
        mdrop    = 1'b0;
        open_upd = open_reg;
        if (lv_reg[mi_idx] != '0) begin
            mdrop    = (open_reg != '0);
            open_upd = open_reg + 1'b1;
        end else if (open_reg != '0) begin
            open_upd = open_reg - 1'b1;
            mdrop    = (open_upd != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
            ov_reg   <= 1'b0;
        end else begin
            if (ov_reg && m_ready && !(st_reg == ST_EMIT && head_due)) begin
                ov_reg <= 1'b0;
            end
            unique case (st_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        if (q_job.is_tick) begin
                            now_reg   <= q_job.t;
                            moved_reg <= 1'b0;
                            st_reg    <= ST_MOVE;
                        end else if (tail_inc != head_reg) begin
                            rt_reg[tail_reg] <= q_job.t;
                            rv_reg[tail_reg] <= q_job.v;
                            tail_reg         <= tail_inc;
                        end
                    end
                end
                ST_MOVE: begin
                    if (head_reg == tail_reg) begin
                        mi_reg   <= '0;
                        open_reg <= '0;
                        st_reg   <= (moved_reg && cfg.merge_overlap && cfg.is_digital)
                                    ? ST_MERGE : ST_EMIT;
                    end else if (cnt_reg >= LIST_CNT_W'(SORTED_DEPTH - 1)) begin
                        st_reg <= ST_EMIT;
                    end else begin
                        moved_reg <= 1'b1;
                        if (time_before(ins_t, now_reg)) begin
                            head_reg <= head_inc;
                        end else begin
                            pos_reg <= cnt_reg;
                            st_reg  <= ST_SCAN;
                        end
                    end
                end
                // walk down one slot a cycle, shifting larger entries up
                ST_SCAN: begin
                    if (scan_stop) begin
                        lt_reg[pos_idx] <= ins_t;
                        lv_reg[pos_idx] <= ins_v;
                        cnt_reg         <= cnt_reg + 1'b1;
                        head_reg        <= head_inc;
                        st_reg          <= ST_MOVE;
                    end else begin
                        lt_reg[pos_idx] <= lt_reg[pm1_idx];
                        lv_reg[pos_idx] <= lv_reg[pm1_idx];
                        pos_reg         <= pos_reg - 1'b1;
                    end
                end
                ST_MERGE: begin
                    if (mi_reg >= cnt_reg) begin
                        st_reg <= ST_EMIT;
                    end else begin
                        open_reg <= open_upd;
                        if (mdrop) begin
                            pos_reg <= mi_reg;
                            cnt_reg <= cnt_reg - 1'b1;
                            st_reg  <= ST_SHIFT;
                        end else begin
                            mi_reg <= mi_reg + 1'b1;
                        end
                    end
                end
                // close the gap at pos one entry a cycle; pos 0 comes from emit
                ST_SHIFT: begin
                    if (pos_reg + 1'b1 > cnt_reg) begin
                        st_reg <= (mi_reg == '0 && open_reg == '0 && !moved_reg)
                                  ? ST_EMIT : ST_MERGE;
                    end else begin
                        lt_reg[pos_idx] <= lt_reg[LIST_IDX_W'(pos_reg + 1'b1)];
                        lv_reg[pos_idx] <= lv_reg[LIST_IDX_W'(pos_reg + 1'b1)];
                        pos_reg         <= pos_reg + 1'b1;
                    end
                end
                ST_EMIT: begin
                    if (!ov_reg || m_ready) begin
                        if (head_due) begin
                            out_reg.due_time  <= lt_reg[0];
                            out_reg.due_value <= lv_reg[0];
                            out_reg.last      <= !((cnt_reg > LIST_CNT_W'(1)) &&
                                                   time_before(lt_reg[1], now_reg));
                            ov_reg    <= 1'b1;
                            cnt_reg   <= cnt_reg - 1'b1;
                            pos_reg   <= '0;
                            mi_reg    <= '0;
                            open_reg  <= '0;
                            moved_reg <= 1'b0;
                            st_reg    <= ST_SHIFT;
                        end else begin
                            st_reg <= ST_IDLE;
                        end
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- design/timed_output_command_scheduler.sv -----
`timescale 1ns / 1ps
// channel  dir  ports                     item
// s_       in   s_valid s_ready s_data    add command or tick
// m_       out  m_valid m_ready m_data    due command with last flag
// apb      in   psel penable pwrite ...   is_digital, merge_overlap
//
// an add is written to the incoming ring unless it is full; a tick walks the
// incoming ring, each insert scanning and shifting the sorted list one slot a
// cycle; then, if an entry moved and merge_overlap and is_digital are set, it
// merges; merge and emit each remove with a one-slot-a-cycle shift. m_ready can stall an emit.
// a two-entry queue keeps taking requests while the back part works, until it is full.
// aresetn is synchronous; list and ring contents are not cleared.
module timed_output_command_scheduler
    import tocs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    cfg_t cfg_reg;
    logic q_valid, q_ready;
    job_t q_job;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.is_digital    <= 1'b1;
            cfg_reg.merge_overlap <= 1'b0;
        end else if (wr_en && paddr[1:0] == 2'b00) begin
            case (paddr[2])
                REG_IS_DIGITAL:    cfg_reg.is_digital    <= pwdata[0];
                REG_MERGE_OVERLAP: cfg_reg.merge_overlap <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_IS_DIGITAL:    prdata[0] = cfg_reg.is_digital;
            REG_MERGE_OVERLAP: prdata[0] = cfg_reg.merge_overlap;
            default: ;
        endcase
    end

    tocs_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid, .q_ready, .q_job
    );

    tocs_back u_back (
        .aclk, .aresetn, .cfg(cfg_reg), .q_valid, .q_ready, .q_job,
        .m_valid, .m_ready, .m_data
    );

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped while stalled");
    a_q_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_ready && q_job.is_tick |=> !q_ready)
        else $error("back part took a tick without leaving idle");
endmodule
